[hw/rtl/gdbprx_pkg.sv]
// ----------------------------------------------------------------------------
// gdbprx_pkg
// Shared types, characters and the checksum digit decoder of the packet
// receiver and checker.
// ----------------------------------------------------------------------------
package gdbprx_pkg;

	localparam logic [7:0] CH_START = 8'h24; // '$'
	localparam logic [7:0] CH_END   = 8'h23; // '#'
	localparam logic [7:0] CH_ACK   = 8'h2B; // '+'
	localparam logic [7:0] CH_NAK   = 8'h2D; // '-'
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'
	localparam logic [7:0] CH_UPA   = 8'h41; // 'A'
	localparam logic [7:0] CH_UPF   = 8'h46; // 'F'
	localparam logic [7:0] CH_LOWA  = 8'h61; // 'a'
	localparam logic [7:0] DIGIT_TEN = 8'd10;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_NAK  = 2'd2
	} kind_t;

	// One byte held in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} in_item_t;

	// Decodes a checksum character. Bytes that are not hex digits fall
	// through the lower-case formula and keep its low four bits.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				t = c - CH_ZERO;
			end else if (c >= CH_UPA && c <= CH_UPF) begin
				t = c - CH_UPA + DIGIT_TEN;
			end else begin
				t = c - CH_LOWA + DIGIT_TEN;
			end
			return t[3:0];
		end
	endfunction

endpackage

[hw/rtl/gdbprx_in_stage.sv]
// ----------------------------------------------------------------------------
// gdbprx_in_stage
// Input register: captures one received byte per transfer and holds it
// until the framing stage can process it.
// ----------------------------------------------------------------------------
module gdbprx_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	input  logic                 advance,
	output gdbprx_pkg::in_item_t item_s1
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// The register is free when empty or when its byte moves on this cycle.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	assign item_s1.valid   = valid_s1;
	assign item_s1.rx_byte = rx_byte_s1;

endmodule

[hw/rtl/gdbprx_deframer.sv]
// ----------------------------------------------------------------------------
// gdbprx_deframer
// Packet state machine with the running checksum, and the result register
// that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module gdbprx_deframer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gdbprx_pkg::in_item_t item_s1,
	output logic                 advance,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [7:0]           data_byte,
	output logic [7:0]           computed_sum
);

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_BODY = 2'd1,
		PH_HI   = 2'd2,
		PH_LO   = 2'd3
	} phase_t;

	phase_t            phase_q;
	logic [7:0]        sum_q;
	logic [3:0]        high_digit_q;
	logic              out_valid_s2;
	gdbprx_pkg::kind_t kind_s2;
	logic [7:0]        data_s2;
	logic [7:0]        sum_s2;

	logic       slot_free;
	logic       step;
	logic [7:0] c;
	logic [7:0] sum_next;
	logic [7:0] sent_sum;
	logic       good;

	assign slot_free = !out_valid_s2 || !out_stall;
	assign advance   = slot_free;
	assign step      = item_s1.valid && slot_free;
	assign c         = item_s1.rx_byte;
	assign sum_next  = sum_q + c;
	assign sent_sum  = {high_digit_q, gdbprx_pkg::hex_value(c)};
	assign good      = (sent_sum == sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			sum_q        <= 8'd0;
			high_digit_q <= 4'd0;
			out_valid_s2 <= 1'b0;
			kind_s2      <= gdbprx_pkg::KIND_DATA;
			data_s2      <= 8'd0;
			sum_s2       <= 8'd0;
		end else if (slot_free) begin
			out_valid_s2 <= 1'b0;
			if (step) begin
				unique case (phase_q)
					PH_HUNT: begin
						if (c == gdbprx_pkg::CH_START) begin
							sum_q   <= 8'd0;
							phase_q <= PH_BODY;
						end
					end
					PH_BODY: begin
						if (c == gdbprx_pkg::CH_END) begin
							phase_q <= PH_HI;
						end else begin
							sum_q        <= sum_next;
							out_valid_s2 <= 1'b1;
							kind_s2      <= gdbprx_pkg::KIND_DATA;
							data_s2      <= c;
							sum_s2       <= sum_next;
						end
					end
					PH_HI: begin
						high_digit_q <= gdbprx_pkg::hex_value(c);
						phase_q      <= PH_LO;
					end
					PH_LO: begin
						out_valid_s2 <= 1'b1;
						kind_s2      <= good ? gdbprx_pkg::KIND_ACK : gdbprx_pkg::KIND_NAK;
						data_s2      <= good ? gdbprx_pkg::CH_ACK : gdbprx_pkg::CH_NAK;
						sum_s2       <= sum_q;
						phase_q      <= PH_HUNT;
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_s2;
	assign kind         = kind_s2;
	assign data_byte    = data_s2;
	assign computed_sum = sum_s2;

	// The second checksum digit always ends the packet with a verdict.
	a_lo_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LO |=> out_valid_s2 && phase_q == PH_HUNT
		&& kind_s2 != gdbprx_pkg::KIND_DATA)
		else $error("checksum digit did not produce a verdict");

	// Hunting never produces a result.
	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_HUNT |=> !out_valid_s2)
		else $error("result produced while hunting");

	// A payload byte is passed out with the updated running sum.
	a_body_sum: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_BODY && c != gdbprx_pkg::CH_END
		|=> out_valid_s2 && sum_s2 == $past(sum_next) && sum_q == sum_s2)
		else $error("payload byte sum mismatch");

	// An ack carries the matching reply character.
	a_reply_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && kind_s2 == gdbprx_pkg::KIND_ACK |-> data_s2 == gdbprx_pkg::CH_ACK)
		else $error("ack without reply character");

endmodule

[hw/rtl/gdb_packet_receiver_checker_top.sv]
// ----------------------------------------------------------------------------
// gdb_packet_receiver_checker_top
// Deframes remote debug packets from a byte stream, streams the payload
// out with its running sum and reports ack or nak on the checksum.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | sink      | in_valid / in_stall | rx_byte
//  out     | source    | out_valid/out_stall | kind, data_byte, computed_sum
//
// One byte is accepted every cycle while in_stall is low; a byte enters the
// input register at its transfer and moves on when the result register is free.
// Each byte gives zero or one result; bytes while hunting, '#' and the first
// checksum digit give none.
// Reset returns the block to hunting with a zero sum and empty registers.
// A stall on the output holds the result register; the input stalls only
// when a byte waits in the input register behind that held result.
module gdb_packet_receiver_checker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] computed_sum
);

	gdbprx_pkg::in_item_t item_s1;
	logic                 advance;

	gdbprx_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	gdbprx_deframer u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_s1      (item_s1),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.computed_sum (computed_sum)
	);

endmodule
